[sv/asn1ts_pkg.sv]
// Shared types, constants and digit helpers for the certificate time converter.
package asn1ts_pkg;

    // Default of the character store depth
    localparam int MAX_CHARS_DEF = 15;

    // Characters of a timestamp that can carry digits
    localparam int DIGIT_CHARS = 14;

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Character codes
    localparam logic [7:0] CH_TERM = 8'h5A;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // Accepted timestamp lengths
    localparam logic [7:0] LEN_UTC = 8'd13;
    localparam logic [7:0] LEN_GEN = 8'd15;

    // Result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_FORMAT = 2'd1;
    localparam logic [1:0] STAT_EARLY  = 2'd2;

    // Calendar constants
    localparam logic [15:0] UTC_PIVOT     = 16'd50;
    localparam logic [15:0] CENTURY_19    = 16'd1900;
    localparam logic [15:0] CENTURY_20    = 16'd2000;
    localparam logic [31:0] DAYS_PER_YEAR = 32'd365;
    localparam logic [31:0] EPOCH_DAYS    = 32'd719561;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [19:0] SECS_PER_HOUR = 20'd3600;
    localparam logic [19:0] SECS_PER_MIN  = 20'd60;

    // Reciprocal for an exact divide by 100 of any 16-bit value
    localparam logic [32:0] RECIP_100   = 33'd83887;
    localparam int          RECIP_100_SH = 23;

    // Reciprocal for an exact divide by 5 of values up to 768
    localparam logic [17:0] RECIP_5    = 18'd205;
    localparam int          RECIP_5_SH = 10;

    // Day-count year term when the year underflows to all ones
    localparam logic [31:0] YDAYS_WRAP = 32'((64'd365 * 64'hFFFF_FFFF
                                             + 64'hFFFF_FFFF / 64'd4
                                             - 64'hFFFF_FFFF / 64'd100
                                             + 64'hFFFF_FFFF / 64'd400));

    // One timestamp handed from front to back
    typedef struct packed {
        logic                              bad;
        logic                              gen;
        logic [DIGIT_CHARS-1:0][7:0]       chars;
        logic [31:0]                       elapsed;
    } t_job;

    // Character to digit, wrapped to 16 bits
    function automatic logic [15:0] digit16(input logic [7:0] c);
        digit16 = {8'h00, c} - {8'h00, CH_ZERO};
    endfunction

    // Two characters to an 8-bit field
    function automatic logic [7:0] pair8(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] dh;
        logic [7:0] dl;
        dh    = hi - CH_ZERO;
        dl    = lo - CH_ZERO;
        pair8 = 8'(dh * 8'd10) + dl;
    endfunction

endpackage

[sv/asn1ts_front.sv]
// Character front end: stores characters, counts length and classifies the timestamp.
module asn1ts_front #(
    parameter int MAX_CHARS = asn1ts_pkg::MAX_CHARS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    input  logic [31:0]        i_elapsed_seconds,
    output logic               o_push,
    output asn1ts_pkg::t_job   o_job,
    input  logic               i_full
);

    localparam int IDX_W = $clog2(MAX_CHARS);

    logic [7:0] r_store [MAX_CHARS];
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic       w_accept;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign n_count  = (r_count == 8'hFF) ? r_count : r_count + 8'd1;
    assign o_push   = w_accept && i_last_char;

    always_comb begin
        o_job.bad = (i_char_code != asn1ts_pkg::CH_TERM)
                 || ((n_count != asn1ts_pkg::LEN_UTC) && (n_count != asn1ts_pkg::LEN_GEN));
        o_job.gen     = (n_count == asn1ts_pkg::LEN_GEN);
        o_job.elapsed = i_elapsed_seconds;
        for (int k = 0; k < asn1ts_pkg::DIGIT_CHARS; k++) begin
            o_job.chars[k] = r_store[k];
        end
    end

    // Drop characters past the end of the store
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_count < 8'(MAX_CHARS))) begin
            r_store[r_count[IDX_W-1:0]] <= i_char_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 8'd0;
        end else if (w_accept) begin
            r_count <= i_last_char ? 8'd0 : n_count;
        end
    end

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_char) |=> (r_count == 8'd0))
        else $error("character count not cleared after last beat");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_last_char && (r_count == 8'hFF)) |=> (r_count == 8'hFF))
        else $error("character count wrapped");

endmodule

[sv/asn1ts_queue.sv]
// Short job queue between the character front end and the conversion back end.
module asn1ts_queue #(
    parameter int DEPTH = asn1ts_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  asn1ts_pkg::t_job   i_job,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output asn1ts_pkg::t_job   o_job
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    asn1ts_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_pop && !w_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(DEPTH))
        else $error("queue fill beyond depth");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

endmodule

[sv/asn1ts_back.sv]
// Conversion back end: turns a queued timestamp into Unix seconds through a sequence of states.
module asn1ts_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  asn1ts_pkg::t_job   i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_unix_seconds,
    output logic [1:0]         o_status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DAYS,
        ST_SCALE,
        ST_OUT
    } t_state;

    t_state      r_state;
    logic        r_o_valid;
    logic [31:0] r_unix_seconds;
    logic [1:0]  r_status;

    // Decoded fields
    logic [15:0] r_y16;
    logic        r_ywrap;
    logic [7:0]  r_m;
    logic [7:0]  r_d;
    logic [7:0]  r_h;
    logic [7:0]  r_mi;
    logic [7:0]  r_s;
    logic [31:0] r_elapsed;

    // Intermediate terms
    logic [31:0] r_y365;
    logic [32:0] r_q100p;
    logic [32:0] r_q400p;
    logic [12:0] r_mterm;
    logic [19:0] r_hms;
    logic [31:0] r_days;
    logic [31:0] r_scaled;
    logic        r_early;

    logic        w_out_free;
    logic        w_load;
    logic [15:0] w_yy;
    logic [15:0] w_year_utc;
    logic [15:0] w_year_gen;
    logic [15:0] w_year;
    logic [7:0]  w_f [10];
    logic [7:0]  n_m;
    logic [15:0] n_y16;
    logic        n_ywrap;
    logic [7:0]  w_mon;
    logic [9:0]  w_m3;
    logic [17:0] w_m3p;
    logic [15:0] w_q100;
    logic [15:0] w_q400;
    logic [31:0] w_sum;

    assign w_out_free = !r_o_valid || i_ready;
    assign o_pop      = (r_state == ST_IDLE) && i_job_valid && w_out_free;
    assign w_load     = (o_pop && i_job.bad) || ((r_state == ST_OUT) && w_out_free);
    assign o_valid    = r_o_valid;
    assign o_unix_seconds = r_unix_seconds;
    assign o_status   = r_status;

    // Decode the queue head
    always_comb begin
        w_yy = 16'(asn1ts_pkg::digit16(i_job.chars[0]) * 16'd10
                   + asn1ts_pkg::digit16(i_job.chars[1]));
        w_year_utc = (w_yy >= asn1ts_pkg::UTC_PIVOT) ? w_yy + asn1ts_pkg::CENTURY_19
                                                     : w_yy + asn1ts_pkg::CENTURY_20;
        w_year_gen = 16'(asn1ts_pkg::digit16(i_job.chars[0]) * 16'd1000
                       + asn1ts_pkg::digit16(i_job.chars[1]) * 16'd100
                       + asn1ts_pkg::digit16(i_job.chars[2]) * 16'd10
                       + asn1ts_pkg::digit16(i_job.chars[3]));
        w_year = i_job.gen ? w_year_gen : w_year_utc;
        for (int k = 0; k < 10; k++) begin
            w_f[k] = i_job.gen ? i_job.chars[k + 4] : i_job.chars[k + 2];
        end
        w_mon = asn1ts_pkg::pair8(w_f[0], w_f[1]);
        // January and February count as months of the year before
        if (w_mon <= 8'd2) begin
            n_m     = w_mon + 8'd12;
            n_y16   = w_year - 16'd1;
            n_ywrap = (w_year == 16'd0);
        end else begin
            n_m     = w_mon;
            n_y16   = w_year;
            n_ywrap = 1'b0;
        end
    end

    always_comb begin
        w_m3   = 10'(({2'b00, r_m} + 10'd1) * 10'd3);
        w_m3p  = {8'h00, w_m3} * asn1ts_pkg::RECIP_5;
        w_q100 = 16'(r_q100p >> asn1ts_pkg::RECIP_100_SH);
        w_q400 = 16'(r_q400p >> asn1ts_pkg::RECIP_100_SH);
        w_sum  = r_scaled + {12'h000, r_hms} + r_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_o_valid && i_ready && !w_load) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_y16     <= n_y16;
                        r_ywrap   <= n_ywrap;
                        r_m       <= n_m;
                        r_d       <= asn1ts_pkg::pair8(w_f[2], w_f[3]);
                        r_h       <= asn1ts_pkg::pair8(w_f[4], w_f[5]);
                        r_mi      <= asn1ts_pkg::pair8(w_f[6], w_f[7]);
                        r_s       <= asn1ts_pkg::pair8(w_f[8], w_f[9]);
                        r_elapsed <= i_job.elapsed;
                        if (i_job.bad) begin
                            r_o_valid      <= 1'b1;
                            r_unix_seconds <= 32'd0;
                            r_status       <= asn1ts_pkg::STAT_FORMAT;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    r_y365  <= {16'h0000, r_y16} * asn1ts_pkg::DAYS_PER_YEAR;
                    r_q100p <= {17'd0, r_y16} * asn1ts_pkg::RECIP_100;
                    r_q400p <= {19'd0, r_y16[15:2]} * asn1ts_pkg::RECIP_100;
                    r_mterm <= 13'({5'd0, r_m} * 13'd30) + {5'd0, w_m3p[17:asn1ts_pkg::RECIP_5_SH]}
                             + {5'd0, r_d};
                    r_hms   <= {12'h000, r_h} * asn1ts_pkg::SECS_PER_HOUR
                             + {12'h000, r_mi} * asn1ts_pkg::SECS_PER_MIN
                             + {12'h000, r_s};
                    r_state <= ST_DAYS;
                end
                ST_DAYS: begin
                    if (r_ywrap) begin
                        r_days <= asn1ts_pkg::YDAYS_WRAP + {19'd0, r_mterm};
                    end else begin
                        r_days <= r_y365 + {18'd0, r_y16[15:2]} - {16'h0000, w_q100}
                                + {16'h0000, w_q400} + {19'd0, r_mterm};
                    end
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_early  <= (r_days < asn1ts_pkg::EPOCH_DAYS);
                    r_scaled <= (r_days - asn1ts_pkg::EPOCH_DAYS) * asn1ts_pkg::SECS_PER_DAY;
                    r_state  <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_o_valid      <= 1'b1;
                        r_unix_seconds <= r_early ? 32'd0 : w_sum;
                        r_status       <= r_early ? asn1ts_pkg::STAT_EARLY
                                                  : asn1ts_pkg::STAT_OK;
                        r_state        <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_status != asn1ts_pkg::STAT_OK)) |-> (r_unix_seconds == 32'd0))
        else $error("non-zero seconds with an error status");

    a_start_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> $past(o_pop))
        else $error("conversion started without taking a job");

endmodule

[sv/asn1_time_to_unix_seconds_top.sv]
// Top level of the certificate time to Unix seconds converter.
// Characters are taken one beat per cycle while the job queue has room.
// A timestamp's result passes from its last beat through the job queue and the back end.
// The back end steps each timestamp through decode, divide, day sum, scale and output,
// and a bad format goes straight to output; it takes no new timestamp until it is idle.
// Reset (synchronous, active low) clears the character count, the queue and the output.
// The character store is not cleared; only characters of the current timestamp are read.
module asn1_time_to_unix_seconds_top #(
    parameter int MAX_CHARS = asn1ts_pkg::MAX_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_last_char,
    input  logic [31:0] i_elapsed_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_unix_seconds,
    output logic [1:0]  o_status
);

    // Front to queue
    logic             w_push;
    asn1ts_pkg::t_job w_push_job;
    logic             w_full;

    // Queue to back
    logic             w_job_valid;
    logic             w_pop;
    asn1ts_pkg::t_job w_head_job;

    // Store characters, count the length and flag format errors on the last beat
    asn1ts_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_char_code       (i_char_code),
        .i_last_char       (i_last_char),
        .i_elapsed_seconds (i_elapsed_seconds),
        .o_push            (w_push),
        .o_job             (w_push_job),
        .i_full            (w_full)
    );

    // Hold finished timestamps so the front keeps taking characters during conversion
    asn1ts_queue #(
        .DEPTH (asn1ts_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .i_pop   (w_pop),
        .o_job   (w_head_job)
    );

    // Convert date and time to seconds and hold the result until taken
    asn1ts_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (w_job_valid),
        .i_job          (w_head_job),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_unix_seconds (o_unix_seconds),
        .o_status       (o_status)
    );

endmodule
